[sv/tsg_pkg.sv]
package tsg_pkg;

   // default build: 12-bit coordinates, up to 64 spans per triangle
   localparam int MAX_SPAN_ROWS_DEF = 64;
   localparam int COORD_BITS_DEF    = 12;

endpackage

[sv/tsg_req_if.sv]
interface tsg_req_if #(
   parameter int COORD_BITS = tsg_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] vertex_a_x;
   logic signed [COORD_BITS-1:0] vertex_a_y;
   logic signed [COORD_BITS-1:0] vertex_b_x;
   logic signed [COORD_BITS-1:0] vertex_b_y;
   logic signed [COORD_BITS-1:0] vertex_c_x;
   logic signed [COORD_BITS-1:0] vertex_c_y;

   modport source (
      output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
      input  ready
   );

   modport sink (
      input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
      output ready
   );
endinterface

[sv/tsg_rsp_if.sv]
interface tsg_rsp_if #(
   parameter int COORD_BITS = tsg_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] row;
   logic signed [COORD_BITS-1:0] span_left;
   logic signed [COORD_BITS-1:0] span_right;
   logic                         last_span;
   logic                         rows_dropped;

   modport source (
      output valid, row, span_left, span_right, last_span, rows_dropped,
      input  ready
   );

   modport sink (
      input  valid, row, span_left, span_right, last_span, rows_dropped,
      output ready
   );
endinterface

[sv/triangle_span_generator.sv]
// channel  | dir | modport | payload
// ---------+-----+---------+------------------------------------------------------
// req_if   | in  | sink    | vertex_a_x/y, vertex_b_x/y, vertex_c_x/y (signed)
// rsp_if   | out | source  | row, span_left, span_right, last_span, rows_dropped
//
// Setup per triangle: a load, the sort compares y1/y2, y1/y3 and y2/y3, and the
// edge divisions (long, upper, lower), the divisions on one shared compare/subtract unit.
// Each span but the last then passes through emit, step long edge and step short
// edge; the last one only through emit.
// req_if.ready is high only when idle.
// A stalled rsp_if holds the span register; the edges still step to the next row, then the sequencer waits in S_ROW.
// Synchronous reset clears the sequencer and the result valid only.
module triangle_span_generator #(
   parameter int MAX_SPAN_ROWS = tsg_pkg::MAX_SPAN_ROWS_DEF,
   parameter int COORD_BITS    = tsg_pkg::COORD_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   tsg_req_if.sink  req_if,
   tsg_rsp_if.source rsp_if
);

   localparam int CB     = COORD_BITS;
   localparam int ROW_W  = (MAX_SPAN_ROWS > 1) ? $clog2(MAX_SPAN_ROWS) : 1;
   localparam int STEP_W = $clog2(COORD_BITS);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_SORT_AB   = 9'b000000010,
      S_SORT_AC   = 9'b000000100,
      S_SORT_BC   = 9'b000001000,
      S_DIV_LOAD  = 9'b000010000,
      S_DIV_RUN   = 9'b000100000,
      S_ROW       = 9'b001000000,
      S_ADV_LONG  = 9'b010000000,
      S_ADV_SHORT = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      SEG_LONG  = 2'd0,
      SEG_UPPER = 2'd1,
      SEG_LOWER = 2'd2
   } seg_sel_type;

   // one edge: start x, direction, denominator, per-row step and running offset
   typedef struct packed {
      logic signed [CB-1:0] x0;
      logic                 neg;
      logic [CB:0]          den;
      logic [CB-1:0]        q0;
      logic [CB-1:0]        r0;
      logic [CB-1:0]        acc_q;
      logic [CB-1:0]        acc_r;
   } seg_type;

   state_type            state_ff, state_in;
   seg_sel_type          edge_sel_ff, edge_sel_in;
   logic signed [CB-1:0] x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff;
   logic signed [CB-1:0] x1_in, y1_in, x2_in, y2_in, x3_in, y3_in;
   seg_type              long_ff, upper_ff, lower_ff;
   seg_type              long_in, upper_in, lower_in;
   logic [CB-1:0]        num_ff, num_in;
   logic [CB-1:0]        rem_ff, rem_in;
   logic [CB:0]          div_den_ff, div_den_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic signed [CB-1:0] row_y_ff, row_y_in;
   logic [ROW_W-1:0]     row_k_ff, row_k_in;
   logic [ROW_W-1:0]     last_k_ff, last_k_in;
   logic                 dropped_ff, dropped_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_load;
   logic signed [CB-1:0] rsp_row_ff, rsp_left_ff, rsp_right_ff;
   logic                 rsp_last_ff, rsp_dropped_ff;

   logic                 req_fire;

   // sort comparator
   logic signed [CB-1:0] cmp_l, cmp_r;
   logic                 cmp_gt;

   // shared compare/subtract unit
   logic [CB:0]          trial;
   logic [CB:0]          unit_den;
   logic [CB:0]          diff;
   logic                 ge;

   // edge endpoints for the division being set up
   logic signed [CB-1:0] ep_xa, ep_ya, ep_xb, ep_yb;
   logic signed [CB:0]   ep_dx;
   logic [CB:0]          ep_mag;
   logic [CB:0]          ep_den;

   logic                 below_mid;
   logic                 upper_half;
   seg_type              adv_seg, short_seg;
   logic [CB:0]          adv_q_sum;
   logic [CB-1:0]        adv_q, adv_r;
   logic signed [CB-1:0] span_s, span_e;
   logic signed [CB:0]   total_m1;
   logic [CB:0]          total;
   logic                 is_last;

   function automatic logic signed [CB-1:0] seg_x(input seg_type s);
      logic signed [CB:0] off;
      logic signed [CB:0] sum;
      off = s.neg ? -$signed({1'b0, s.acc_q}) : $signed({1'b0, s.acc_q});
      sum = $signed({s.x0[CB-1], s.x0}) + off;
      return sum[CB-1:0];
   endfunction

   assign req_fire  = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == S_IDLE);

   assign below_mid  = (row_y_ff < y2_ff);
   assign upper_half = (row_y_ff <= y2_ff);
   assign is_last    = (row_k_ff == last_k_ff);

   always_comb begin
      unique case (state_ff)
         S_SORT_AB: begin
            cmp_l = y1_ff;
            cmp_r = y2_ff;
         end
         S_SORT_AC: begin
            cmp_l = y1_ff;
            cmp_r = y3_ff;
         end
         S_SORT_BC: begin
            cmp_l = y2_ff;
            cmp_r = y3_ff;
         end
         default: begin
            cmp_l = y1_ff;
            cmp_r = y2_ff;
         end
      endcase
   end

   assign cmp_gt = (cmp_l > cmp_r);

   always_comb begin
      unique case (edge_sel_ff)
         SEG_UPPER: begin
            ep_xa = x1_ff;
            ep_ya = y1_ff;
            ep_xb = x2_ff;
            ep_yb = y2_ff;
         end
         SEG_LOWER: begin
            ep_xa = x2_ff;
            ep_ya = y2_ff;
            ep_xb = x3_ff;
            ep_yb = y3_ff;
         end
         default: begin
            ep_xa = x1_ff;
            ep_ya = y1_ff;
            ep_xb = x3_ff;
            ep_yb = y3_ff;
         end
      endcase
   end

   assign ep_dx  = $signed({ep_xb[CB-1], ep_xb}) - $signed({ep_xa[CB-1], ep_xa});
   assign ep_mag = ep_dx[CB] ? (CB+1)'(-ep_dx) : (CB+1)'(ep_dx);
   assign ep_den = (CB+1)'($signed({ep_yb[CB-1], ep_yb}) - $signed({ep_ya[CB-1], ep_ya}))
                   + (CB+1)'(1);

   assign total_m1 = $signed({y3_ff[CB-1], y3_ff}) - $signed({y1_ff[CB-1], y1_ff});
   assign total    = (CB+1)'(total_m1) + (CB+1)'(1);

   assign adv_seg   = (state_ff == S_ADV_LONG) ? long_ff : (below_mid ? upper_ff : lower_ff);
   assign short_seg = upper_half ? upper_ff : lower_ff;

   always_comb begin
      if (state_ff == S_DIV_RUN) begin
         trial    = {rem_ff, num_ff[CB-1]};
         unit_den = div_den_ff;
      end else begin
         trial    = {1'b0, adv_seg.acc_r} + {1'b0, adv_seg.r0};
         unit_den = adv_seg.den;
      end
   end

   assign ge   = (trial >= unit_den);
   assign diff = trial - unit_den;

   assign adv_q_sum = {1'b0, adv_seg.acc_q} + {1'b0, adv_seg.q0} + (CB+1)'(ge);
   assign adv_q     = adv_q_sum[CB-1:0];
   assign adv_r     = ge ? diff[CB-1:0] : trial[CB-1:0];

   always_comb begin
      logic signed [CB-1:0] sx;
      logic signed [CB-1:0] ex;
      sx = seg_x(short_seg);
      ex = seg_x(long_ff);
      if (sx > ex) begin
         span_s = ex;
         span_e = sx;
      end else begin
         span_s = sx;
         span_e = ex;
      end
   end

   always_comb begin
      state_in     = state_ff;
      edge_sel_in  = edge_sel_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      x3_in        = x3_ff;
      y3_in        = y3_ff;
      long_in      = long_ff;
      upper_in     = upper_ff;
      lower_in     = lower_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      div_den_in   = div_den_ff;
      step_in      = step_ff;
      row_y_in     = row_y_ff;
      row_k_in     = row_k_ff;
      last_k_in    = last_k_ff;
      dropped_in   = dropped_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               x1_in    = req_if.vertex_a_x;
               y1_in    = req_if.vertex_a_y;
               x2_in    = req_if.vertex_b_x;
               y2_in    = req_if.vertex_b_y;
               x3_in    = req_if.vertex_c_x;
               y3_in    = req_if.vertex_c_y;
               state_in = S_SORT_AB;
            end
         end
         S_SORT_AB: begin
            if (cmp_gt) begin
               x1_in = x2_ff;
               y1_in = y2_ff;
               x2_in = x1_ff;
               y2_in = y1_ff;
            end
            state_in = S_SORT_AC;
         end
         S_SORT_AC: begin
            if (cmp_gt) begin
               x1_in = x3_ff;
               y1_in = y3_ff;
               x3_in = x1_ff;
               y3_in = y1_ff;
            end
            state_in = S_SORT_BC;
         end
         S_SORT_BC: begin
            if (cmp_gt) begin
               x2_in = x3_ff;
               y2_in = y3_ff;
               x3_in = x2_ff;
               y3_in = y2_ff;
            end
            edge_sel_in = SEG_LONG;
            state_in    = S_DIV_LOAD;
         end
         S_DIV_LOAD: begin
            num_in     = ep_mag[CB-1:0];
            rem_in     = '0;
            div_den_in = ep_den;
            step_in    = STEP_W'(COORD_BITS - 1);
            unique case (edge_sel_ff)
               SEG_UPPER: begin
                  upper_in.x0    = ep_xa;
                  upper_in.neg   = ep_dx[CB];
                  upper_in.den   = ep_den;
                  upper_in.acc_q = '0;
                  upper_in.acc_r = '0;
               end
               SEG_LOWER: begin
                  lower_in.x0    = ep_xa;
                  lower_in.neg   = ep_dx[CB];
                  lower_in.den   = ep_den;
                  lower_in.acc_q = '0;
                  lower_in.acc_r = '0;
               end
               default: begin
                  long_in.x0    = ep_xa;
                  long_in.neg   = ep_dx[CB];
                  long_in.den   = ep_den;
                  long_in.acc_q = '0;
                  long_in.acc_r = '0;
                  row_y_in      = y1_ff;
                  row_k_in      = '0;
                  if (total > (CB+1)'(MAX_SPAN_ROWS)) begin
                     dropped_in = 1'b1;
                     last_k_in  = ROW_W'(MAX_SPAN_ROWS - 1);
                  end else begin
                     dropped_in = 1'b0;
                     last_k_in  = total_m1[ROW_W-1:0];
                  end
               end
            endcase
            state_in = S_DIV_RUN;
         end
         S_DIV_RUN: begin
            // restoring divide, one quotient bit per cycle
            num_in  = {num_ff[CB-2:0], ge};
            rem_in  = ge ? diff[CB-1:0] : trial[CB-1:0];
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               unique case (edge_sel_ff)
                  SEG_UPPER: begin
                     upper_in.q0 = num_in;
                     upper_in.r0 = rem_in;
                     edge_sel_in = SEG_LOWER;
                     state_in    = S_DIV_LOAD;
                  end
                  SEG_LOWER: begin
                     lower_in.q0 = num_in;
                     lower_in.r0 = rem_in;
                     state_in    = S_ROW;
                  end
                  default: begin
                     long_in.q0  = num_in;
                     long_in.r0  = rem_in;
                     edge_sel_in = SEG_UPPER;
                     state_in    = S_DIV_LOAD;
                  end
               endcase
            end
         end
         S_ROW: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = is_last ? S_IDLE : S_ADV_LONG;
            end
         end
         S_ADV_LONG: begin
            long_in.acc_q = adv_q;
            long_in.acc_r = adv_r;
            state_in      = S_ADV_SHORT;
         end
         S_ADV_SHORT: begin
            // upper edge runs down to the middle row, lower edge takes over after it
            if (below_mid) begin
               upper_in.acc_q = adv_q;
               upper_in.acc_r = adv_r;
            end else begin
               lower_in.acc_q = adv_q;
               lower_in.acc_r = adv_r;
            end
            row_y_in = row_y_ff + CB'(1);
            row_k_in = row_k_ff + ROW_W'(1);
            state_in = S_ROW;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_sel_ff <= edge_sel_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      x2_ff       <= x2_in;
      y2_ff       <= y2_in;
      x3_ff       <= x3_in;
      y3_ff       <= y3_in;
      long_ff     <= long_in;
      upper_ff    <= upper_in;
      lower_ff    <= lower_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      div_den_ff  <= div_den_in;
      step_ff     <= step_in;
      row_y_ff    <= row_y_in;
      row_k_ff    <= row_k_in;
      last_k_ff   <= last_k_in;
      dropped_ff  <= dropped_in;
      if (rsp_load) begin
         rsp_row_ff     <= row_y_ff;
         rsp_left_ff    <= span_s;
         rsp_right_ff   <= span_e;
         rsp_last_ff    <= is_last;
         rsp_dropped_ff <= is_last && dropped_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.row          = rsp_row_ff;
   assign rsp_if.span_left    = rsp_left_ff;
   assign rsp_if.span_right   = rsp_right_ff;
   assign rsp_if.last_span    = rsp_last_ff;
   assign rsp_if.rows_dropped = rsp_dropped_ff;

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SORT_BC |=> (y1_ff <= y2_ff) && (y2_ff <= y3_ff))
      else $error("vertices not sorted by y after the third compare");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV_RUN |-> {1'b0, rem_ff} < div_den_ff)
      else $error("divider remainder not below divisor");

   a_long_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADV_LONG |=> {1'b0, long_ff.acc_r} < long_ff.den)
      else $error("long edge remainder out of range after step");

   a_drop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dropped_ff |-> rsp_last_ff)
      else $error("rows_dropped flagged on a span that is not last");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_SORT_AB && !req_if.ready)
      else $error("sequencer did not start on an accepted triangle");

endmodule
